/* sv/kli_pkg.sv */
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types, widths and codes for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  // Table geometry
  localparam int MAX_KEYS = 16;
  localparam int IDX_W    = $clog2(MAX_KEYS);

  // Fixed field widths
  localparam int Q_W        = 32;  // Q16.16 time and value
  localparam int COUNT_W    = 5;   // key_count register
  localparam int KEY_IDX_W  = 4;   // key_index field
  localparam int SRC_W      = 3;   // result_source field
  localparam int CFG_IDX_W  = 2;   // configuration register index
  localparam int FRAC_W     = 16;  // fraction bits of the factor
  localparam int FACT_W     = FRAC_W + 1;  // factor 0..1.0 inclusive

  typedef logic signed [Q_W-1:0] q16_t;

  // Request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL   = 2'd1;

  // Result source codes
  localparam logic [SRC_W-1:0] SRC_NEUTRAL = 3'd0;
  localparam logic [SRC_W-1:0] SRC_FIRST   = 3'd1;
  localparam logic [SRC_W-1:0] SRC_INTERP  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_ZERO    = 3'd3;
  localparam logic [SRC_W-1:0] SRC_LAST    = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/kli_channels.sv */
// ----------------------------------------------------------------------------
// kli_channels
// Valid/ready channels of the interpolator: key and query requests, results
// and configuration writes.
// ----------------------------------------------------------------------------
interface kli_req_if;
  import kli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [KEY_IDX_W-1:0] key_index;
  q16_t                 key_time;
  q16_t                 key_value;
  q16_t                 query_time;

  modport source (output valid, mode, key_index, key_time, key_value, query_time,
                  input ready);
  modport sink   (input valid, mode, key_index, key_time, key_value, query_time,
                  output ready);
endinterface

interface kli_res_if;
  import kli_pkg::*;
  logic             valid;
  logic             ready;
  q16_t             result_value;
  logic [SRC_W-1:0] result_source;

  modport source (output valid, result_value, result_source, input ready);
  modport sink   (input valid, result_value, result_source, output ready);
endinterface

interface kli_cfg_if;
  import kli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [Q_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/kli_div.sv */
// ----------------------------------------------------------------------------
// kli_div
// Serial restoring divider for the interpolation factor:
// floor(off * 2^16 / gap) with 0 < gap and 0 < off <= gap, one quotient bit
// per cycle after the integer bit taken at start.
// ----------------------------------------------------------------------------
module kli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kli_pkg::Q_W-1:0]    off,
  input  logic [kli_pkg::Q_W-1:0]    gap,
  output kli_pkg::div_stat_t         stat,
  output logic [kli_pkg::FACT_W-1:0] quot
);
  import kli_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [Q_W-1:0]   divisor;
  logic [Q_W-1:0]   rem;
  logic [Q_W:0]     rem_sh;
  logic             fits;

  // Shift the partial remainder and trial-subtract
  always_comb begin
    rem_sh = {rem, 1'b0};
    fits   = (rem_sh >= {1'b0, divisor});
  end

  // Control: busy for FRAC_W steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: integer bit at start, then one fraction bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= gap;
      if (off >= gap) begin
        rem  <= off - gap;
        quot <= FACT_W'(1);
      end else begin
        rem  <= off;
        quot <= '0;
      end
    end else if (busy) begin
      if (fits) begin
        rem <= Q_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[Q_W-1:0];
      end
      quot <= {quot[FACT_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* sv/keyframe_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Key write: stored when the request is taken. Query: for an empty table the
// neutral result goes straight to emit; otherwise the first key is read, then
// one memory read per later key scanned (up to MAX_KEYS - 1), then for
// interpolation the serial divider, multiply and add.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken. Reset clears control state,
// key_count and neutral_value; the key table is undefined until written.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator (
  input  logic clk,
  input  logic rst,
  kli_cfg_if.sink   cfg,
  kli_req_if.sink   req,
  kli_res_if.source res
);
  import kli_pkg::*;

  localparam int PROD_W = Q_W + 1 + FACT_W + 1;

  // Configuration registers
  logic [COUNT_W-1:0] key_count;
  q16_t               neutral_value;

  // Key memory: {time, value} per entry
  logic [2*Q_W-1:0] mem [MAX_KEYS];
  logic [2*Q_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  q16_t             rd_time;
  q16_t             rd_value;

  // Sequencer
  state_t state;
  state_t state_next;

  // Query working registers
  q16_t                     query;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         idx;
  q16_t                     prev_time;
  q16_t                     prev_value;
  q16_t                     cur_value;
  logic [FACT_W-1:0]        factor;
  logic signed [PROD_W-1:0] product;
  q16_t                     res_value;
  logic [SRC_W-1:0]         res_source;

  // Output register
  logic             out_valid;
  q16_t             out_value;
  logic [SRC_W-1:0] out_source;

  // Control decoded from state
  logic               req_take;
  logic               slot_free;
  logic [COUNT_W-1:0] n_keys;
  logic               hit;
  logic signed [Q_W:0] gap;
  logic signed [Q_W:0] off;
  logic               div_start;
  div_stat_t          div_stat;
  logic [FACT_W-1:0]  div_quot;
  logic signed [Q_W:0] diff;
  logic signed [PROD_W-1:0] sum;

  assign rd_time  = rd_data[2*Q_W-1:Q_W];
  assign rd_value = rd_data[Q_W-1:0];

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && (state == ST_IDLE);
  assign wr_en     = req_take && (req.mode == MODE_WRITE);
  assign slot_free = !out_valid || res.ready;
  assign cfg.ready = 1'b1;

  // Clamp the key count to the table depth
  assign n_keys = (key_count > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count;

  // Compare and gap terms for the entry just read
  assign hit  = (query <= rd_time);
  assign gap  = (Q_W+1)'(rd_time) - (Q_W+1)'(prev_time);
  assign off  = (Q_W+1)'(query) - (Q_W+1)'(prev_time);
  assign diff = (Q_W+1)'(cur_value) - (Q_W+1)'(prev_value);
  assign sum  = PROD_W'(prev_value) + (product >>> FRAC_W);

  // Write and read the key memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(req.key_index)] <= {req.key_time, req.key_value};
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      neutral_value <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_COUNT: key_count     <= cfg.data[COUNT_W-1:0];
        REG_NEUTRAL:   neutral_value <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next state, read address and divider start
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_take && req.mode == MODE_EVAL) begin
          state_next = (n_keys == '0) ? ST_EMIT : ST_FIRST;
        end
      end
      ST_FIRST: begin
        rd_addr = IDX_W'(1);
        if (last_idx == '0 || hit) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = idx + 1'b1;
        if (hit) begin
          if (gap <= 0) begin
            state_next = ST_EMIT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else if (idx == last_idx) begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        query      <= req.query_time;
        last_idx   <= IDX_W'(n_keys - 1'b1);
        res_value  <= neutral_value;
        res_source <= SRC_NEUTRAL;
      end
      ST_FIRST: begin
        res_value  <= rd_value;
        res_source <= SRC_FIRST;
        prev_time  <= rd_time;
        prev_value <= rd_value;
        idx        <= IDX_W'(1);
      end
      ST_SCAN: begin
        cur_value <= rd_value;
        if (hit) begin
          res_value  <= rd_value;
          res_source <= SRC_ZERO;
        end else begin
          res_value  <= rd_value;
          res_source <= SRC_LAST;
          prev_time  <= rd_time;
          prev_value <= rd_value;
          idx        <= idx + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          factor <= div_quot;
        end
      end
      ST_MUL: begin
        product <= PROD_W'(diff) * PROD_W'($signed({1'b0, factor}));
      end
      ST_SUM: begin
        res_value  <= sum[Q_W-1:0];
        res_source <= SRC_INTERP;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Output register: load from the sequencer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_value  <= res_value;
      out_source <= res_source;
    end
  end

  assign res.valid         = out_valid;
  assign res.result_value  = out_value;
  assign res.result_source = out_source;

  // Factor divider
  kli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .off   (off[Q_W-1:0]),
    .gap   (gap[Q_W-1:0]),
    .stat  (div_stat),
    .quot  (div_quot)
  );

endmodule
